@@ rtl/tgc_pkg.sv @@
// Shared types and constants of the text console glyph cursor.
// Used by every module of the block; depends on nothing else.
package tgc_pkg;

    localparam int COL_W      = 12;
    localparam int ROW_W      = 8;
    localparam int PIX_W      = 12;
    localparam int MASK_W     = 16;
    localparam int COLOR_W    = 32;
    localparam int CLIP_W     = 13;
    localparam int GW_W       = 5;
    localparam int GLYPH_ROWS = 16;
    localparam int ROWIDX_W   = 4;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [COL_W-1:0]    COL_MAX  = 12'hFFF;
    localparam logic [ROW_W-1:0]    ROW_MAX  = 8'hFF;
    localparam logic [PIX_W-1:0]    PIX_MAX  = 12'hFFF;
    localparam logic [ROWIDX_W-1:0] ROW_LAST = 4'd15;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic ACTION_DRAW   = 1'b0;
    localparam logic ACTION_SCROLL = 1'b1;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_ENABLE      = 2'd0;
    localparam logic [1:0] REG_CLIP_WIDTH  = 2'd1;
    localparam logic [1:0] REG_CLIP_HEIGHT = 2'd2;
    localparam logic [1:0] REG_TEXT_COLOR  = 2'd3;

    localparam logic [CLIP_W-1:0] CLIP_WIDTH_RESET  = 13'd640;
    localparam logic [CLIP_W-1:0] CLIP_HEIGHT_RESET = 13'd480;

    typedef logic [GLYPH_ROWS-1:0][MASK_W-1:0] glyph_t;

    typedef struct packed {
        logic               enable;
        logic [CLIP_W-1:0]  clip_width;
        logic [CLIP_W-1:0]  clip_height;
        logic [COLOR_W-1:0] text_color;
    } cfg_t;

    // One character's worth of pending results.
    typedef struct packed {
        logic               scroll;
        logic               draw;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   base_y;
        logic [COLOR_W-1:0] color;
        glyph_t             rows;
    } job_t;

endpackage

@@ rtl/tgc_in_if.sv @@
// Character request channel of the text console glyph cursor.
// Depends on tgc_pkg for field widths.
interface tgc_in_if;
    import tgc_pkg::*;

    logic              valid;
    logic              ready;
    logic [7:0]        char_code;
    logic              glyph_found;
    logic [GW_W-1:0]   glyph_width;
    logic [63:0]       glyph_rows_a;
    logic [63:0]       glyph_rows_b;
    logic [63:0]       glyph_rows_c;
    logic [63:0]       glyph_rows_d;

    modport source (
        output valid, char_code, glyph_found, glyph_width,
               glyph_rows_a, glyph_rows_b, glyph_rows_c, glyph_rows_d,
        input  ready
    );

    modport sink (
        input  valid, char_code, glyph_found, glyph_width,
               glyph_rows_a, glyph_rows_b, glyph_rows_c, glyph_rows_d,
        output ready
    );
endinterface

@@ rtl/tgc_out_if.sv @@
// Result request channel of the text console glyph cursor.
// Depends on tgc_pkg for field widths.
interface tgc_out_if;
    import tgc_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [MASK_W-1:0]  row_mask;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;

    modport source (
        output valid, action, pixel_x, pixel_y, row_mask, pixel_color, last,
        input  ready
    );

    modport sink (
        input  valid, action, pixel_x, pixel_y, row_mask, pixel_color, last,
        output ready
    );
endinterface

@@ rtl/tgc_regs.sv @@
// APB-style configuration registers of the text console glyph cursor.
// Depends on tgc_pkg for the register indexes and the cfg_t struct.
module tgc_regs
    import tgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_ENABLE:      cfg_next.enable      = pwdata[0];
                REG_CLIP_WIDTH:  cfg_next.clip_width  = pwdata[CLIP_W-1:0];
                REG_CLIP_HEIGHT: cfg_next.clip_height = pwdata[CLIP_W-1:0];
                REG_TEXT_COLOR:  cfg_next.text_color  = pwdata[COLOR_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b1;
            cfg_reg.clip_width  <= CLIP_WIDTH_RESET;
            cfg_reg.clip_height <= CLIP_HEIGHT_RESET;
            cfg_reg.text_color  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ENABLE:      prdata = PDATA_W'(cfg_reg.enable);
            REG_CLIP_WIDTH:  prdata = PDATA_W'(cfg_reg.clip_width);
            REG_CLIP_HEIGHT: prdata = PDATA_W'(cfg_reg.clip_height);
            REG_TEXT_COLOR:  prdata = cfg_reg.text_color;
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/tgc_cursor.sv @@
// Cursor tracking and per-character decisions: newline, space, wrap and scroll.
// Depends on tgc_pkg and tgc_in_if; hands a job_t to the result emitter.
module tgc_cursor
    import tgc_pkg::*;
#(
    parameter int LINE_PITCH = 17,
    parameter int CELL_PITCH = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    tgc_in_if.sink char_in,
    input  logic   job_ready,
    output logic   job_valid,
    output job_t   job
);

    // The row's top pixel line is kept alongside the row so no multiply is needed.
    localparam int ROWY_W = $clog2(((2 ** ROW_W) + 1) * LINE_PITCH + 1);
    localparam int NT_W   = (ROWY_W > CLIP_W) ? ROWY_W : CLIP_W;
    localparam int WRAP_W = $clog2((2 ** COL_W) * CELL_PITCH + (2 ** GW_W));

    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [ROWY_W-1:0] rowy_reg, rowy_next;

    logic              acc;
    logic [NT_W-1:0]   next_top;
    logic              nl_scroll;
    logic              nl_step;
    logic [WRAP_W-1:0] wrap_sum;
    logic              wrap;
    logic [WRAP_W-1:0] px_full;
    logic [PIX_W-1:0]  px_sat;
    logic [ROWY_W-1:0] rowy_inc;
    logic [ROWY_W-1:0] base_full;
    logic [COL_W-1:0]  col_inc;

    assign char_in.ready = job_ready;
    assign acc = char_in.valid && job_ready;

    assign next_top  = NT_W'(rowy_reg) + NT_W'(2 * LINE_PITCH);
    assign nl_scroll = next_top >= NT_W'(cfg.clip_height);
    assign nl_step   = !nl_scroll && (row_reg != ROW_MAX);
    assign rowy_inc  = rowy_reg + ROWY_W'(LINE_PITCH);

    assign wrap_sum = (WRAP_W'(col_reg) + WRAP_W'(1)) * WRAP_W'(CELL_PITCH)
                      + WRAP_W'(char_in.glyph_width);
    assign wrap     = wrap_sum > WRAP_W'(cfg.clip_width);

    assign px_full = WRAP_W'(col_reg) * WRAP_W'(CELL_PITCH);
    assign px_sat  = (px_full > WRAP_W'(PIX_MAX)) ? PIX_MAX : px_full[PIX_W-1:0];

    assign base_full = (wrap && nl_step) ? rowy_inc : rowy_reg;
    assign col_inc   = (col_reg != COL_MAX) ? col_reg + COL_W'(1) : col_reg;

    always_comb
    begin
        job.scroll  = 1'b1;
        job.draw    = 1'b0;
        job.pixel_x = wrap ? '0 : px_sat;
        job.base_y  = (base_full > ROWY_W'(PIX_MAX)) ? PIX_MAX : base_full[PIX_W-1:0];
        job.color   = cfg.text_color;
        job.rows    = {char_in.glyph_rows_d, char_in.glyph_rows_c,
                       char_in.glyph_rows_b, char_in.glyph_rows_a};

        col_next  = col_reg;
        row_next  = row_reg;
        rowy_next = rowy_reg;
        job_valid = 1'b0;

        if (acc && cfg.enable)
        begin
            if (char_in.char_code == CHAR_NEWLINE)
            begin
                col_next  = '0;
                job_valid = nl_scroll;
                if (nl_step)
                begin
                    row_next  = row_reg + ROW_W'(1);
                    rowy_next = rowy_inc;
                end
            end
            else if (char_in.char_code == CHAR_SPACE)
            begin
                col_next = col_inc;
            end
            else if (char_in.glyph_found)
            begin
                job_valid  = 1'b1;
                job.draw   = 1'b1;
                job.scroll = wrap && nl_scroll;
                if (wrap)
                begin
                    col_next = COL_W'(1);
                    if (nl_step)
                    begin
                        row_next  = row_reg + ROW_W'(1);
                        rowy_next = rowy_inc;
                    end
                end
                else
                begin
                    col_next = col_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            rowy_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            rowy_reg <= rowy_next;
        end
    end

endmodule

@@ rtl/tgc_emit.sv @@
// Result emitter: walks one job through an optional scroll and, for a glyph, sixteen row writes.
// Depends on tgc_pkg and tgc_out_if; the output register sits on res_out.
module tgc_emit
    import tgc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_ready,
    tgc_out_if.source  res_out
);

    logic                busy_reg,    busy_next;
    logic                scroll_reg,  scroll_next;
    logic                draw_reg,    draw_next;
    logic [ROWIDX_W-1:0] idx_reg,     idx_next;
    job_t                job_reg,     job_next;
    logic                ovalid_reg,  ovalid_next;
    logic                action_reg,  action_next;
    logic [PIX_W-1:0]    px_reg,      px_next;
    logic [PIX_W-1:0]    py_reg,      py_next;
    logic [MASK_W-1:0]   mask_reg,    mask_next;
    logic [COLOR_W-1:0]  color_reg,   color_next;
    logic                last_reg,    last_next;

    logic                emit;
    logic                finishing;
    logic [PIX_W:0]      py_sum;

    assign emit      = busy_reg && (!ovalid_reg || res_out.ready);
    assign finishing = emit && (scroll_reg ? !draw_reg : (idx_reg == ROW_LAST));
    assign job_ready = !busy_reg || finishing;

    // Base line is already clamped, so one carry bit decides saturation.
    assign py_sum = {1'b0, job_reg.base_y} + (PIX_W + 1)'(idx_reg);

    always_comb
    begin
        busy_next   = busy_reg;
        scroll_next = scroll_reg;
        draw_next   = draw_reg;
        idx_next    = idx_reg;
        job_next    = job_reg;

        if (job_valid)
        begin
            busy_next   = 1'b1;
            scroll_next = job.scroll;
            draw_next   = job.draw;
            idx_next    = '0;
            job_next    = job;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            if (scroll_reg)
            begin
                scroll_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + ROWIDX_W'(1);
            end
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        action_next = action_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        mask_next   = mask_reg;
        color_next  = color_reg;
        last_next   = last_reg;

        if (emit)
        begin
            ovalid_next = 1'b1;
            if (scroll_reg)
            begin
                action_next = ACTION_SCROLL;
                px_next     = '0;
                py_next     = '0;
                mask_next   = '0;
                color_next  = '0;
                last_next   = !draw_reg;
            end
            else
            begin
                action_next = ACTION_DRAW;
                px_next     = job_reg.pixel_x;
                py_next     = py_sum[PIX_W] ? PIX_MAX : py_sum[PIX_W-1:0];
                mask_next   = job_reg.rows[idx_reg];
                color_next  = job_reg.color;
                last_next   = (idx_reg == ROW_LAST);
            end
        end
        else if (res_out.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            scroll_reg <= 1'b0;
            draw_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            scroll_reg <= scroll_next;
            draw_reg   <= draw_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        action_reg <= action_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        mask_reg   <= mask_next;
        color_reg  <= color_next;
        last_reg   <= last_next;
    end

    assign res_out.valid       = ovalid_reg;
    assign res_out.action      = action_reg;
    assign res_out.pixel_x     = px_reg;
    assign res_out.pixel_y     = py_reg;
    assign res_out.row_mask    = mask_reg;
    assign res_out.pixel_color = color_reg;
    assign res_out.last        = last_reg;

endmodule

@@ rtl/text_console_glyph_cursor.sv @@
// Text console glyph cursor: top level with the APB register port.
// Depends on tgc_pkg, tgc_in_if, tgc_out_if, tgc_regs, tgc_cursor and tgc_emit.
//
// The cursor moves in the cycle a character is taken. A glyph
// character produces sixteen row writes on res_out, seventeen when a wrap
// forces a scroll first; a newline at the bottom produces one scroll command;
// everything else produces nothing. Results leave one per cycle through the
// output register while res_out is ready, so a glyph character holds the input
// until its last result enters the output register, and the next character is
// taken in that same cycle. Characters with no results still wait until the
// emitter can take a job. Throughput is set by the single result channel; a
// stalled res_out stalls char_in once a job is pending.
module text_console_glyph_cursor
    import tgc_pkg::*;
#(
    parameter int LINE_PITCH = 17,
    parameter int CELL_PITCH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    tgc_in_if.sink             char_in,
    tgc_out_if.source          res_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t cfg;
    job_t job;
    logic job_valid;
    logic job_ready;

    tgc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgc_cursor #(
        .LINE_PITCH (LINE_PITCH),
        .CELL_PITCH (CELL_PITCH)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .char_in   (char_in),
        .job_ready (job_ready),
        .job_valid (job_valid),
        .job       (job)
    );

    tgc_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .res_out   (res_out)
    );

endmodule

@@ dv/tb_text_console_glyph_cursor.sv @@
// Testbench for text_console_glyph_cursor: drives character requests and APB
// register writes, predicts every row write and scroll command, and checks them.
// Depends on tgc_pkg, tgc_in_if, tgc_out_if and the RTL of the block.
module tb_text_console_glyph_cursor;
    import tgc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_PITCH   = 17;
    localparam int CELL_PITCH   = 8;
    localparam int QUIET_CYCLES = 8;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [7:0]       code;
        logic             found;
        logic [GW_W-1:0]  width;
        logic [3:0][63:0] rows;
    } char_req_t;

    typedef struct packed {
        logic               action;
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [MASK_W-1:0]  mask;
        logic [COLOR_W-1:0] color;
        logic               last;
    } glyph_write_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tgc_in_if  char_if ();
    tgc_out_if res_if ();

    text_console_glyph_cursor #(
        .LINE_PITCH (LINE_PITCH),
        .CELL_PITCH (CELL_PITCH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_if),
        .res_out (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted console state and register copies.
    logic               console_on = 1'b1;
    logic [CLIP_W-1:0]  area_w     = CLIP_WIDTH_RESET;
    logic [CLIP_W-1:0]  area_h     = CLIP_HEIGHT_RESET;
    logic [COLOR_W-1:0] fg_color   = '0;
    logic [COL_W-1:0]   model_col  = '0;
    logic [ROW_W-1:0]   model_line = '0;

    glyph_write_t pending_writes[$];

    int  err_count       = 0;
    int  requests_sent   = 0;
    int  writes_checked  = 0;
    int  scrolls_checked = 0;
    int  burst_left      = 0;
    bit  sender_idle_on  = 1'b1;
    bit  long_hold_req   = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Moves to the start of the next line; returns 1 when a scroll is needed.
    function automatic bit line_break();
        int next_top;
        next_top  = (int'(model_line) + 2) * LINE_PITCH;
        model_col = '0;
        if (next_top >= int'(area_h))
            return 1'b1;
        if (model_line != ROW_MAX)
            model_line++;
        return 1'b0;
    endfunction

    function automatic void push_scroll(input logic is_last);
        glyph_write_t w;
        w        = '0;
        w.action = ACTION_SCROLL;
        w.last   = is_last;
        pending_writes.push_back(w);
    endfunction

    function automatic void predict_glyph_writes(input char_req_t c);
        glyph_write_t w;
        int px;
        int py;
        int base_y;
        if (!console_on)
            return;
        if (c.code == CHAR_NEWLINE)
        begin
            if (line_break())
                push_scroll(1'b1);
            return;
        end
        if (c.code == CHAR_SPACE)
        begin
            if (model_col != COL_MAX)
                model_col++;
            return;
        end
        if (!c.found)
            return;
        if ((int'(model_col) + 1) * CELL_PITCH + int'(c.width) > int'(area_w))
        begin
            if (line_break())
                push_scroll(1'b0);
        end
        px = int'(model_col) * CELL_PITCH;
        if (px > int'(PIX_MAX))
            px = int'(PIX_MAX);
        base_y = int'(model_line) * LINE_PITCH;
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            py = base_y + r;
            if (py > int'(PIX_MAX))
                py = int'(PIX_MAX);
            w.action = ACTION_DRAW;
            w.x      = px[PIX_W-1:0];
            w.y      = py[PIX_W-1:0];
            w.mask   = c.rows[r >> 2][(r & 3) * 16 +: 16];
            w.color  = fg_color;
            w.last   = (r == int'(ROW_LAST));
            pending_writes.push_back(w);
        end
        if (model_col != COL_MAX)
            model_col++;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %h actual %h", $realtime, name, want, got);
        end
    endfunction

    // Compares every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        glyph_write_t want;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (pending_writes.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result: expected none actual action %b x %0d y %0d",
                         $realtime, res_if.action, res_if.pixel_x, res_if.pixel_y);
            end
            else
            begin
                want = pending_writes.pop_front();
                check_field("action", 32'(want.action), 32'(res_if.action));
                check_field("pixel_x", 32'(want.x), 32'(res_if.pixel_x));
                check_field("pixel_y", 32'(want.y), 32'(res_if.pixel_y));
                check_field("row_mask", 32'(want.mask), 32'(res_if.row_mask));
                check_field("pixel_color", want.color, res_if.pixel_color);
                check_field("last", 32'(want.last), 32'(res_if.last));
                if (want.action == ACTION_SCROLL)
                    scrolls_checked++;
                else
                    writes_checked++;
            end
        end
    end

    // Result receiver: changes its stall pattern now and then, and holds off
    // for a long stretch when the test asks for it.
    initial
    begin : result_receiver
        int hold_left;
        int mode;
        int mode_left;
        int tick;
        hold_left    = 0;
        mode         = 0;
        mode_left    = 0;
        tick         = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 4);
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= ($urandom_range(0, 3) != 0);
                    2: res_if.ready <= ($urandom_range(0, 1) == 1);
                    3: res_if.ready <= ((tick % 7) < 4);
                    default: res_if.ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // Offers one character and returns when it is taken, or after the gap that
    // ends a burst. Valid stays high into the next request unless there is a gap.
    task automatic send_char(input char_req_t c);
        int gap;
        char_if.valid        <= 1'b1;
        char_if.char_code    <= c.code;
        char_if.glyph_found  <= c.found;
        char_if.glyph_width  <= c.width;
        char_if.glyph_rows_a <= c.rows[0];
        char_if.glyph_rows_b <= c.rows[1];
        char_if.glyph_rows_c <= c.rows[2];
        char_if.glyph_rows_d <= c.rows[3];
        @(posedge clk);
        while (char_if.ready !== 1'b1)
            @(posedge clk);
        predict_glyph_writes(c);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                char_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic char_req_t glyph_req(input logic [7:0] code, input int width,
                                            input logic [3:0][63:0] rows);
        char_req_t c;
        c.code  = code;
        c.found = 1'b1;
        c.width = width[GW_W-1:0];
        c.rows  = rows;
        return c;
    endfunction

    function automatic logic [3:0][63:0] random_rows();
        logic [3:0][63:0] rows;
        case ($urandom_range(0, 9))
            0: rows = '0;
            1: rows = '1;
            default:
                for (int i = 0; i < 4; i++)
                    rows[i] = {$urandom, $urandom};
        endcase
        return rows;
    endfunction

    // Mostly found glyphs of random code, with newlines, spaces and missing glyphs mixed in.
    function automatic char_req_t random_request();
        char_req_t c;
        int pick;
        pick    = $urandom_range(0, 99);
        c.code  = 8'($urandom_range(0, 255));
        c.found = 1'b1;
        if ($urandom_range(0, 9) == 0)
            c.width = GW_W'($urandom_range(17, 31));
        else
            c.width = GW_W'($urandom_range(0, 16));
        c.rows  = random_rows();
        if (pick < 10)
        begin
            c.code  = CHAR_NEWLINE;
            c.found = 1'($urandom_range(0, 1));
        end
        else if (pick < 20)
        begin
            c.code  = CHAR_SPACE;
            c.found = 1'($urandom_range(0, 1));
        end
        else if (pick < 27)
            c.found = 1'b0;
        return c;
    endfunction

    function automatic char_req_t control_req(input logic [7:0] code);
        char_req_t c;
        c.code  = code;
        c.found = 1'($urandom_range(0, 1));
        c.width = GW_W'($urandom_range(0, 31));
        c.rows  = random_rows();
        return c;
    endfunction

    // Stops offering and waits for every predicted result, then for a quiet stretch.
    task automatic wait_results_drained();
        if (char_if.valid === 1'b1)
            char_if.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // One APB transfer; psel stays high so that writes can follow back to back.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        case (idx)
            REG_ENABLE:      console_on = value[0];
            REG_CLIP_WIDTH:  area_w     = value[CLIP_W-1:0];
            REG_CLIP_HEIGHT: area_h     = value[CLIP_W-1:0];
            REG_TEXT_COLOR:  fg_color   = value;
            default:         ;
        endcase
    endtask

    task automatic set_console(input logic en, input int w, input int h,
                               input logic [31:0] color);
        wait_results_drained();
        apb_write(REG_ENABLE, {31'd0, en});
        apb_write(REG_CLIP_WIDTH, 32'(w));
        apb_write(REG_CLIP_HEIGHT, 32'(h));
        apb_write(REG_TEXT_COLOR, color);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Glyphs under the reset configuration, including the control characters.
    task automatic test_reset_defaults();
        logic [3:0][63:0] ramp;
        char_req_t c;
        for (int r = 0; r < GLYPH_ROWS; r++)
            ramp[r >> 2][(r & 3) * 16 +: 16] = {r[3:0], ~r[3:0], 8'hA5 ^ r[7:0]};
        send_char(glyph_req(8'h41, 8, ramp));
        send_char(glyph_req(8'hFF, 16, '1));
        send_char(glyph_req(8'h00, 0, '0));
        send_char(glyph_req(CHAR_SPACE, 16, ramp));
        c       = glyph_req(8'h42, 8, ramp);
        c.found = 1'b0;
        send_char(c);
        send_char(glyph_req(CHAR_NEWLINE, 8, ramp));
        send_char(glyph_req(8'h7E, 31, random_rows()));
    endtask

    // Exact fit at the right edge, wraps without a scroll, then wraps that scroll.
    task automatic test_wrap_and_scroll();
        set_console(1'b1, 24, 4096, 32'hFFFF_FFFF);
        send_char(control_req(CHAR_NEWLINE));
        send_char(glyph_req(8'h57, 16, random_rows()));
        send_char(glyph_req(8'h69, 0, random_rows()));
        send_char(glyph_req(8'h6C, 0, random_rows()));
        send_char(glyph_req(8'h6D, 1, random_rows()));
        set_console(1'b1, 24, 40, 32'h1234_5678);
        send_char(glyph_req(8'h23, 16, random_rows()));
        send_char(control_req(CHAR_NEWLINE));
    endtask

    // With the console off nothing happens and the cursor stays where it was.
    task automatic test_disabled();
        set_console(1'b0, 640, 480, $urandom);
        send_char(glyph_req(8'h51, 8, random_rows()));
        send_char(control_req(CHAR_NEWLINE));
        send_char(control_req(CHAR_SPACE));
        set_console(1'b1, 640, 480, $urandom);
        send_char(glyph_req(8'h52, 8, random_rows()));
    endtask

    // Zero and maximal clip sizes are used as written.
    task automatic test_clip_extremes();
        set_console(1'b1, 0, 0, $urandom);
        send_char(glyph_req(8'h30, 4, random_rows()));
        send_char(control_req(CHAR_NEWLINE));
        set_console(1'b1, 8191, 8191, 32'h0000_0000);
        send_char(glyph_req(8'h31, 16, random_rows()));
        send_char(control_req(CHAR_SPACE));
        set_console(1'b1, 4096, 4096, 32'hFFFF_FFFF);
        send_char(glyph_req(8'h32, 16, random_rows()));
    endtask

    // Random text in phases of growing height; the cursor line never moves up.
    task automatic test_random_text();
        int heights[5];
        int w;
        heights = '{60, 200, 480, 1000, 4096};
        for (int p = 0; p < 5; p++)
        begin
            w = (p == 4) ? 4096 : $urandom_range(9, 160);
            set_console(1'b1, w, heights[p], $urandom);
            sender_idle_on = (p != 0);
            for (int i = 0; i < 35; i++)
                send_char(random_request());
        end
        sender_idle_on = 1'b1;
    endtask

    // The receiver holds off while glyphs keep coming, so the block stalls its input.
    task automatic test_backpressure();
        wait_results_drained();
        long_hold_req  = 1'b1;
        sender_idle_on = 1'b0;
        for (int i = 0; i < 8; i++)
            send_char(glyph_req(8'h41 + 8'(i), $urandom_range(0, 16), random_rows()));
        wait_results_drained();
        sender_idle_on = 1'b1;
    endtask

    // Drives the line to its limit and draws at saturated pixel lines on the way.
    task automatic test_cursor_saturation();
        set_console(1'b1, 8191, 8191, $urandom);
        send_char(control_req(CHAR_NEWLINE));
        for (int i = 0; i < 270; i++)
        begin
            send_char(control_req(CHAR_NEWLINE));
            if (i % 15 == 14)
                send_char(glyph_req(8'h5A, $urandom_range(0, 16), random_rows()));
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        char_if.valid        = 1'b0;
        char_if.char_code    = '0;
        char_if.glyph_found  = 1'b0;
        char_if.glyph_width  = '0;
        char_if.glyph_rows_a = '0;
        char_if.glyph_rows_b = '0;
        char_if.glyph_rows_c = '0;
        char_if.glyph_rows_d = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_wrap_and_scroll();
        test_disabled();
        test_clip_extremes();
        test_random_text();
        test_backpressure();
        test_cursor_saturation();

        wait_results_drained();
        $display("Sent %0d character requests across reset, wrap, scroll, disable,",
                 requests_sent);
        $display("clip-extreme, random and saturation cases; checked %0d row writes, %0d scrolls.",
                 writes_checked, scrolls_checked);
        if (err_count == 0)
            $display("PASS text_console_glyph_cursor");
        else
            $display("FAIL text_console_glyph_cursor");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Timed out with %0d results still expected.", pending_writes.size());
        $display("FAIL text_console_glyph_cursor");
        $finish;
    end

endmodule
